// ----- src/qlu_pkg.sv -----
// ----------------------------------------------------------------------------
// qlu_pkg: shared types and constants of the Q-learning update block
// Table geometry, fixed-point widths, register codes and table/MAC control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qlu_pkg;

    // table geometry, both counts are powers of two
    localparam int NUM_ACTIONS = 4;
    localparam int NUM_STATES  = 1024;
    localparam int ACT_W       = $clog2(NUM_ACTIONS);
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int ADDR_W      = STATE_W + ACT_W;
    localparam int CNT_W       = ACT_W + 1;

    // input fields
    localparam int IDX_W  = 10;
    localparam int WAIT_W = 10;

    // fixed point
    localparam int Q_W      = 32;
    localparam int RATE_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int OP_A_W   = RATE_W + 1;
    localparam int OP_B_W   = Q_W + 2;
    localparam int PROD_W   = OP_A_W + OP_B_W;
    localparam int ACC_W    = PROD_W + 1;

    localparam logic [RATE_W-1:0] ONE_Q16     = 17'h10000;
    localparam logic [RATE_W-1:0] ALPHA_RESET = 17'd6554;
    localparam logic [RATE_W-1:0] GAMMA_RESET = 17'd58982;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 2'd1;

    typedef struct packed {
        logic                    rd;
        logic [STATE_W-1:0]      rd_state;
        logic [ACT_W-1:0]        rd_action;
        logic                    wr;
        logic [STATE_W-1:0]      wr_state;
        logic [ACT_W-1:0]        wr_action;
        logic signed [Q_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic load;
        logic add;
    } t_mac_ctrl;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        return (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

endpackage

// ----- src/qlu_qtable.sv -----
// ----------------------------------------------------------------------------
// qlu_qtable: Q value table
// One read and one write port, registered read data, zeroing sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlu_qtable (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qlu_pkg::t_mem_req             i_req,
    output logic signed [qlu_pkg::Q_W-1:0] o_rdata,
    output logic                          o_clearing
);

    localparam int DEPTH = 1 << qlu_pkg::ADDR_W;

    logic signed [qlu_pkg::Q_W-1:0] mem [0:DEPTH-1];
    logic signed [qlu_pkg::Q_W-1:0] r_rdata;
    logic [qlu_pkg::ADDR_W-1:0]     r_clr_addr;
    logic                           r_clearing;

    logic                           we;
    logic [qlu_pkg::ADDR_W-1:0]     waddr;
    logic signed [qlu_pkg::Q_W-1:0] wdata;
    logic [qlu_pkg::ADDR_W-1:0]     raddr;

    always_comb begin
        we    = r_clearing | i_req.wr;
        waddr = r_clearing ? r_clr_addr : {i_req.wr_state, i_req.wr_action};
        wdata = r_clearing ? '0 : i_req.wdata;
        raddr = {i_req.rd_state, i_req.rd_action};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {qlu_pkg::ADDR_W{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_req.rd) begin
            r_rdata <= mem[raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

    // sequencer must keep off the table during the sweep
    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(i_req.rd || i_req.wr))
        else $error("table accessed during zeroing sweep");

endmodule

// ----- src/qlu_mac.sv -----
// ----------------------------------------------------------------------------
// qlu_mac: shared multiply-accumulate unit
// Registered 18x34 signed product feeding a load/add accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qlu_mac (
    input  logic                              i_clk,
    input  qlu_pkg::t_mac_ctrl                i_ctrl,
    input  logic signed [qlu_pkg::OP_A_W-1:0] i_op_a,
    input  logic signed [qlu_pkg::OP_B_W-1:0] i_op_b,
    output logic signed [qlu_pkg::PROD_W-1:0] o_prod,
    output logic signed [qlu_pkg::ACC_W-1:0]  o_acc
);

    logic signed [qlu_pkg::PROD_W-1:0] r_prod;
    logic signed [qlu_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
        if (i_ctrl.load) begin
            r_acc <= qlu_pkg::ACC_W'(r_prod);
        end else if (i_ctrl.add) begin
            r_acc <= r_acc + qlu_pkg::ACC_W'(r_prod);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

// ----- src/tabular_q_learning_update_top.sv -----
// ----------------------------------------------------------------------------
// tabular_q_learning_update_top: Q-learning table update and greedy choice
// Requests are handled one at a time: a new one is taken only once the last
// result is registered; table reads go in turn through the single read port.
// Sync reset runs a zeroing sweep of the whole table before o_ready rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabular_q_learning_update_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [qlu_pkg::IDX_W-1:0]            i_state_index,
    input  logic [qlu_pkg::WAIT_W-1:0]           i_wait_count,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [qlu_pkg::ACT_W-1:0]            o_chosen_action,
    output logic signed [qlu_pkg::Q_W-1:0]       o_updated_value,
    output logic                                 o_update_done,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [qlu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [qlu_pkg::RATE_W-1:0]           i_cfg_data
);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_IDLE     = 12'b0000_0000_0010,
        S_RD_MAX   = 12'b0000_0000_0100,
        S_RD_OLD   = 12'b0000_0000_1000,
        S_MUL_G    = 12'b0000_0001_0000,
        S_TGT      = 12'b0000_0010_0000,
        S_MUL_A    = 12'b0000_0100_0000,
        S_ACC      = 12'b0000_1000_0000,
        S_WR       = 12'b0001_0000_0000,
        S_RD_BEST  = 12'b0010_0000_0000,
        S_BEST_END = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    localparam int ACT_W  = qlu_pkg::ACT_W;
    localparam int CNT_W  = qlu_pkg::CNT_W;
    localparam int Q_W    = qlu_pkg::Q_W;
    localparam int OP_B_W = qlu_pkg::OP_B_W;
    localparam int ACC_W  = qlu_pkg::ACC_W;

    t_state r_state, n_state;

    logic [CNT_W-1:0]            r_cnt;
    logic [qlu_pkg::STATE_W-1:0] r_cur;
    logic [qlu_pkg::WAIT_W-1:0]  r_wait;
    logic [qlu_pkg::STATE_W-1:0] r_prev_state;
    logic [qlu_pkg::WAIT_W-1:0]  r_prev_wait;
    logic [ACT_W-1:0]            r_last_action;
    logic [ACT_W-1:0]            r_best;
    logic                        r_have_prev;
    logic [qlu_pkg::RATE_W-1:0]  r_alpha;
    logic [qlu_pkg::RATE_W-1:0]  r_gamma;
    logic signed [Q_W-1:0]       r_maxq;
    logic signed [Q_W-1:0]       r_bestval;
    logic signed [OP_B_W-1:0]    r_target;
    logic signed [Q_W-1:0]       r_new_value;

    logic                        r_out_valid;
    logic [ACT_W-1:0]            r_out_action;
    logic signed [Q_W-1:0]       r_out_value;
    logic                        r_out_done;

    qlu_pkg::t_mem_req           mem_req;
    qlu_pkg::t_mac_ctrl          mac_ctrl;
    logic signed [Q_W-1:0]       tbl_rdata;
    logic                        tbl_clearing;
    logic signed [qlu_pkg::OP_A_W-1:0] op_a;
    logic signed [OP_B_W-1:0]    op_b;
    logic signed [qlu_pkg::PROD_W-1:0] mac_prod;
    logic signed [ACC_W-1:0]     mac_acc;

    logic [qlu_pkg::RATE_W-1:0]  alpha_c;
    logic [qlu_pkg::RATE_W-1:0]  gamma_c;
    logic [qlu_pkg::RATE_W-1:0]  one_minus_alpha;
    logic signed [qlu_pkg::WAIT_W:0] reward;
    logic signed [OP_B_W-1:0]    target;
    logic signed [ACC_W-1:0]     acc_sh;
    logic signed [Q_W-1:0]       sat_value;
    logic                        accept;
    logic                        out_load;
    logic                        max_arrive;
    logic                        max_first;
    logic                        best_arrive;
    logic [CNT_W-1:0]            best_idx;
    logic                        best_take;
    logic                        best_init;

    qlu_qtable u_qtable (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rdata    (tbl_rdata),
        .o_clearing (tbl_clearing)
    );

    qlu_mac u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (mac_prod),
        .o_acc  (mac_acc)
    );

    // datapath helpers
    always_comb begin
        alpha_c         = qlu_pkg::clamp_rate(r_alpha);
        gamma_c         = qlu_pkg::clamp_rate(r_gamma);
        one_minus_alpha = qlu_pkg::ONE_Q16 - alpha_c;
        reward          = $signed({1'b0, r_prev_wait}) - $signed({1'b0, r_wait});
        // arithmetic shift gives the floor of the Q16 product
        target          = (OP_B_W'(reward) <<< qlu_pkg::FRAC_W)
                        + OP_B_W'(mac_prod >>> qlu_pkg::FRAC_W);
        acc_sh          = mac_acc >>> qlu_pkg::FRAC_W;
        if (acc_sh > ACC_W'(qlu_pkg::Q_MAX)) begin
            sat_value = qlu_pkg::Q_MAX;
        end else if (acc_sh < ACC_W'(qlu_pkg::Q_MIN)) begin
            sat_value = qlu_pkg::Q_MIN;
        end else begin
            sat_value = Q_W'(acc_sh);
        end
    end

    // read data is registered, so it arrives in the cycle after the address
    always_comb begin
        max_arrive  = ((r_state == S_RD_MAX) && (r_cnt != '0)) || (r_state == S_RD_OLD);
        max_first   = (r_state == S_RD_MAX) && (r_cnt == CNT_W'(1));
        best_arrive = ((r_state == S_RD_BEST) && (r_cnt != '0)) || (r_state == S_BEST_END);
        best_idx    = (r_state == S_BEST_END) ? CNT_W'(qlu_pkg::NUM_ACTIONS)
                                              : r_cnt - CNT_W'(1);
        // first read of the pass is the current best, then every action in order
        best_init   = best_arrive && (best_idx == '0);
        best_take   = best_arrive && (best_idx != '0) && (tbl_rdata > r_bestval);
        accept      = i_valid && o_ready;
        out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        mem_req  = '0;
        mac_ctrl = '0;
        op_a     = '0;
        op_b     = '0;
        case (r_state)
            S_CLEAR: begin
                if (!tbl_clearing) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = r_have_prev ? S_RD_MAX : S_RD_BEST;
                end
            end
            S_RD_MAX: begin
                mem_req.rd        = 1'b1;
                mem_req.rd_state  = r_cur;
                mem_req.rd_action = r_cnt[ACT_W-1:0];
                if (r_cnt == CNT_W'(qlu_pkg::NUM_ACTIONS - 1)) begin
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                mem_req.rd        = 1'b1;
                mem_req.rd_state  = r_prev_state;
                mem_req.rd_action = r_last_action;
                n_state           = S_MUL_G;
            end
            S_MUL_G: begin
                op_a    = {1'b0, gamma_c};
                op_b    = OP_B_W'(r_maxq);
                n_state = S_TGT;
            end
            S_TGT: begin
                op_a    = {1'b0, one_minus_alpha};
                op_b    = OP_B_W'(tbl_rdata);
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                op_a          = {1'b0, alpha_c};
                op_b          = r_target;
                mac_ctrl.load = 1'b1;
                n_state       = S_ACC;
            end
            S_ACC: begin
                mac_ctrl.add = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                mem_req.wr        = 1'b1;
                mem_req.wr_state  = r_prev_state;
                mem_req.wr_action = r_last_action;
                mem_req.wdata     = sat_value;
                n_state           = S_RD_BEST;
            end
            S_RD_BEST: begin
                mem_req.rd        = 1'b1;
                mem_req.rd_state  = r_cur;
                mem_req.rd_action = (r_cnt == '0) ? r_best : ACT_W'(r_cnt - CNT_W'(1));
                if (r_cnt == CNT_W'(qlu_pkg::NUM_ACTIONS)) begin
                    n_state = S_BEST_END;
                end
            end
            S_BEST_END: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_prev_state  <= '0;
            r_prev_wait   <= '0;
            r_last_action <= '0;
            r_best        <= ACT_W'(1);
            r_have_prev   <= 1'b0;
            r_alpha       <= qlu_pkg::ALPHA_RESET;
            r_gamma       <= qlu_pkg::GAMMA_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            case (r_state)
                S_RD_MAX: begin
                    r_cnt <= (n_state == S_RD_OLD) ? '0 : r_cnt + CNT_W'(1);
                end
                S_RD_BEST: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase

            if (best_take) begin
                r_best <= ACT_W'(best_idx - CNT_W'(1));
            end

            if (out_load) begin
                r_prev_state  <= r_cur;
                r_prev_wait   <= r_wait;
                r_last_action <= r_best;
                r_have_prev   <= 1'b1;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    qlu_pkg::REG_LEARNING_RATE: r_alpha <= i_cfg_data;
                    qlu_pkg::REG_DISCOUNT:      r_gamma <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur  <= qlu_pkg::STATE_W'(i_state_index);
            r_wait <= i_wait_count;
        end
        if (max_arrive && (max_first || (tbl_rdata > r_maxq))) begin
            r_maxq <= tbl_rdata;
        end
        if (best_init || best_take) begin
            r_bestval <= tbl_rdata;
        end
        if (r_state == S_TGT) begin
            r_target <= target;
        end
        if (r_state == S_WR) begin
            r_new_value <= sat_value;
        end
        if (out_load) begin
            r_out_action <= r_best;
            r_out_value  <= r_have_prev ? r_new_value : '0;
            r_out_done   <= r_have_prev;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_chosen_action = r_out_action;
    assign o_updated_value = r_out_value;
    assign o_update_done   = r_out_done;
    assign o_cfg_ready     = 1'b1;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while previous one in flight");

    a_no_update_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_update_done) |-> (o_updated_value == '0))
        else $error("nonzero value reported without a table update");

    a_write_needs_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> r_have_prev)
        else $error("table write before any previous state");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_valid && (r_state == S_IDLE)))
        else $error("result not presented after sequence end");

endmodule

// ----- tb/tabular_q_learning_update_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_update_top_tb: self-checking bench for the Q update block
// Sensed states go in through a queue-fed driver; a local Q table follows the
// update rule and greedy choice, and a monitor checks every decision in order.
// ----------------------------------------------------------------------------

module tabular_q_learning_update_top_tb;

    localparam int NUM_ACTIONS = qlu_pkg::NUM_ACTIONS;
    localparam int NUM_STATES  = qlu_pkg::NUM_STATES;
    localparam int IDX_W       = qlu_pkg::IDX_W;
    localparam int WAIT_W      = qlu_pkg::WAIT_W;
    localparam int ACT_W       = qlu_pkg::ACT_W;
    localparam int STATE_W     = qlu_pkg::STATE_W;
    localparam int Q_W         = qlu_pkg::Q_W;
    localparam int RATE_W      = qlu_pkg::RATE_W;
    localparam int FRAC_W      = qlu_pkg::FRAC_W;
    localparam int CFG_IDX_W   = qlu_pkg::CFG_IDX_W;

    localparam logic [RATE_W-1:0]      ONE_Q16           = qlu_pkg::ONE_Q16;
    localparam logic [RATE_W-1:0]      ALPHA_RESET       = qlu_pkg::ALPHA_RESET;
    localparam logic [RATE_W-1:0]      GAMMA_RESET       = qlu_pkg::GAMMA_RESET;
    localparam logic signed [Q_W-1:0]  Q_MAX             = qlu_pkg::Q_MAX;
    localparam logic signed [Q_W-1:0]  Q_MIN             = qlu_pkg::Q_MIN;
    localparam logic [CFG_IDX_W-1:0]   REG_LEARNING_RATE = qlu_pkg::REG_LEARNING_RATE;
    localparam logic [CFG_IDX_W-1:0]   REG_DISCOUNT      = qlu_pkg::REG_DISCOUNT;

    localparam int TABLE_SIZE    = NUM_STATES * NUM_ACTIONS;
    localparam int HOT_COUNT     = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef struct packed {
        logic [IDX_W-1:0]  state_index;
        logic [WAIT_W-1:0] wait_count;
    } t_sensed;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic signed [Q_W-1:0] value;
        logic                  done;
    } t_decision;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [IDX_W-1:0]      i_state_index = '0;
    logic [WAIT_W-1:0]     i_wait_count  = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [ACT_W-1:0]      o_chosen_action;
    logic signed [Q_W-1:0] o_updated_value;
    logic                  o_update_done;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [RATE_W-1:0]     i_cfg_data    = '0;

    tabular_q_learning_update_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_state_index   (i_state_index),
        .i_wait_count    (i_wait_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_chosen_action (o_chosen_action),
        .o_updated_value (o_updated_value),
        .o_update_done   (o_update_done),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    t_sensed   pending_requests[$];
    t_decision pending_decisions[$];
    t_sensed   next_req;
    t_decision want;
    int        mismatch_count = 0;
    int        src_idle_pct   = 0;
    int        snk_stall_pct  = 0;

    logic [IDX_W-1:0] hot_states [HOT_COUNT];

    // local copy of the learner
    logic signed [Q_W-1:0] q_table [TABLE_SIZE];
    logic [STATE_W-1:0]    last_state;
    logic [WAIT_W-1:0]     last_wait;
    logic [ACT_W-1:0]      taken_action;
    logic [ACT_W-1:0]      greedy_action;
    bit                    seen_first;
    logic [RATE_W-1:0]     alpha_reg;
    logic [RATE_W-1:0]     gamma_reg;

    function automatic void clear_model();
        foreach (q_table[k]) q_table[k] = '0;
        last_state    = '0;
        last_wait     = '0;
        taken_action  = '0;
        greedy_action = ACT_W'(1);
        seen_first    = 1'b0;
        alpha_reg     = ALPHA_RESET;
        gamma_reg     = GAMMA_RESET;
    endfunction

    function automatic t_decision q_update_predict(input t_sensed req);
        longint    alpha, gamma, reward, max_q, target, mix, nv;
        int        cur, slot;
        t_decision r;
        cur     = int'(req.state_index) % NUM_STATES;
        r.value = '0;
        r.done  = 1'b0;
        if (seen_first) begin
            alpha  = (alpha_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(alpha_reg);
            gamma  = (gamma_reg > ONE_Q16) ? longint'(ONE_Q16) : longint'(gamma_reg);
            reward = longint'(last_wait) - longint'(req.wait_count);
            max_q  = q_table[cur * NUM_ACTIONS];
            for (int a = 1; a < NUM_ACTIONS; a++) begin
                if (q_table[cur * NUM_ACTIONS + a] > max_q) begin
                    max_q = q_table[cur * NUM_ACTIONS + a];
                end
            end
            // arithmetic shift of a signed product rounds towards minus infinity
            target = reward * 65536 + ((gamma * max_q) >>> FRAC_W);
            slot   = int'(last_state) * NUM_ACTIONS + int'(taken_action);
            mix    = (65536 - alpha) * longint'(q_table[slot]) + alpha * target;
            nv     = mix >>> FRAC_W;
            if (nv > longint'(Q_MAX)) nv = longint'(Q_MAX);
            if (nv < longint'(Q_MIN)) nv = longint'(Q_MIN);
            q_table[slot] = nv[Q_W-1:0];
            r.value       = nv[Q_W-1:0];
            r.done        = 1'b1;
        end
        // ties leave the previous choice in place
        for (int a = 0; a < NUM_ACTIONS; a++) begin
            if (q_table[cur * NUM_ACTIONS + int'(greedy_action)]
                    < q_table[cur * NUM_ACTIONS + a]) begin
                greedy_action = ACT_W'(a);
            end
        end
        last_state   = STATE_W'(cur);
        last_wait    = req.wait_count;
        taken_action = greedy_action;
        seen_first   = 1'b1;
        r.action     = greedy_action;
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pending_decisions.push_back(q_update_predict({i_state_index, i_wait_count}));
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_req = pending_requests.pop_front();
                    i_valid       <= 1'b1;
                    i_state_index <= next_req.state_index;
                    i_wait_count  <= next_req.wait_count;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // decision monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_decisions.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected decision action %0d value %0d done %0d",
                                 $realtime, o_chosen_action, o_updated_value, o_update_done);
                    end
                end else begin
                    want = pending_decisions.pop_front();
                    if (o_chosen_action !== want.action || o_updated_value !== want.value ||
                        o_update_done !== want.done) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"%0t: mismatch exp action %0d value %0d done %0d, ",
                                      "got %0d %0d %0d"},
                                     $realtime, want.action, want.value, want.done,
                                     o_chosen_action, o_updated_value, o_update_done);
                        end
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    function automatic void queue_req(input logic [IDX_W-1:0] st, input logic [WAIT_W-1:0] cars);
        t_sensed r;
        r.state_index = st;
        r.wait_count  = cars;
        pending_requests.push_back(r);
    endfunction

    function automatic logic [IDX_W-1:0] pick_state();
        if ($urandom_range(3) == 0) return IDX_W'($urandom);
        return hot_states[$urandom_range(HOT_COUNT-1)];
    endfunction

    function automatic logic [WAIT_W-1:0] pick_wait();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return WAIT_W'($urandom);
        endcase
    endfunction

    function automatic void queue_random(input int n_items);
        int               left, kind, run_len, cars;
        logic [IDX_W-1:0] st_a, st_b;
        left = n_items;
        while (left > 0) begin
            kind = $urandom_range(9);
            if (kind < 4 || left < 3) begin
                queue_req(pick_state(), pick_wait());
                left--;
            end else if (kind < 7) begin
                // rising queue in one state drives its values down
                st_a    = pick_state();
                cars    = $urandom_range(255);
                run_len = $urandom_range(6, 3);
                if (run_len > left) run_len = left;
                for (int k = 0; k < run_len; k++) begin
                    queue_req(st_a, WAIT_W'(cars));
                    cars += $urandom_range(300, 50);
                    if (cars > 1023) cars = 1023;
                end
                left -= run_len;
            end else begin
                // drain into another state then refill: pushes values up
                st_a = pick_state();
                st_b = pick_state();
                queue_req(st_a, WAIT_W'($urandom_range(1023, 768)));
                queue_req(st_b, WAIT_W'($urandom_range(255)));
                queue_req(st_b, WAIT_W'($urandom_range(1023, 768)));
                left -= 3;
            end
        end
    endfunction

    task automatic drain();
        while (pending_requests.size() != 0 || i_valid || pending_decisions.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [RATE_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == REG_LEARNING_RATE) begin
            alpha_reg = value;
        end else begin
            gamma_reg = value;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(input logic [RATE_W-1:0] alpha, input logic [RATE_W-1:0] gamma,
                             input int src_pct, input int snk_pct);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_LEARNING_RATE, alpha);
        write_reg(REG_DISCOUNT, gamma);
        @(negedge i_clk);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    initial begin : stimulus
        logic [IDX_W-1:0] st_a, st_b;
        clear_model();
        hot_states[0] = '0;
        hot_states[1] = '1;
        for (int k = 2; k < HOT_COUNT; k++) hot_states[k] = IDX_W'($urandom);

        // directed, reset rates: first request, extreme states and rewards
        queue_req(10'd12, 10'd1023);
        queue_req(10'd12, 10'd0);
        queue_req(10'd12, 10'd0);
        queue_req(10'd1023, 10'd1023);
        queue_req(10'd0, 10'd0);
        queue_req(10'd0, 10'd1023);
        queue_req(10'd1023, 10'd0);
        queue_req(10'd12, 10'd1023);
        queue_req(10'd1023, 10'd1023);
        queue_req(10'd0, 10'd0);
        queue_req(10'h2AA, 10'h155);
        queue_req(10'h155, 10'h2AA);
        queue_req(10'h2AA, 10'h2AA);
        queue_req(10'd12, 10'd0);
        queue_req(10'd12, 10'd1023);
        queue_req(10'd0, 10'd512);
        queue_random(100);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full rates: repeated drain/refill cycles climb into positive saturation
        set_phase(ONE_Q16, ONE_Q16, 73, 0);
        st_a = IDX_W'($urandom);
        st_b = st_a ^ IDX_W'(1);
        for (int k = 0; k < 40; k++) begin
            queue_req(st_a, 10'd1023);
            queue_req(st_b, 10'd0);
            queue_req(st_b, 10'd1023);
        end
        queue_random(40);

        // no learning, rate above one clamped
        set_phase('0, '1, 0, 73);
        queue_random(90);

        set_phase('1, '0, 38, 38);
        queue_random(90);

        set_phase(RATE_W'($urandom), RATE_W'($urandom), 38, 38);
        queue_random(140);

        set_phase(RATE_W'(65535), RATE_W'(1), 0, 0);
        queue_random(80);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        mismatch_count += pending_decisions.size();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/qlu_pkg.sv
src/qlu_qtable.sv
src/qlu_mac.sv
src/tabular_q_learning_update_top.sv
tb/tabular_q_learning_update_top_tb.sv
